@@ hdl/mexp_pkg.sv @@
package mexp_pkg;

	// Operand width of the datapath and the configuration registers.
	localparam int WIDTH = 32;
	// Width of a bit position within one operand.
	localparam int IDX_W = $clog2(WIDTH);

	// Configuration register indexes.
	localparam int REG_IDX_W = 2;
	localparam logic [REG_IDX_W-1:0] REG_MODULUS = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_PUBLIC_EXP = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_PRIVATE_EXP = 2'd2;

	// Item classes decided by the front end.
	localparam int CLS_W = 2;
	localparam logic [CLS_W-1:0] CLS_ONE = 2'd0;
	localparam logic [CLS_W-1:0] CLS_ZERO = 2'd1;
	localparam logic [CLS_W-1:0] CLS_POW = 2'd2;

	// Depth of the queue between front and back end.
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// One classified item, with the operands it needs.
	typedef struct packed {
		logic [CLS_W-1:0] cls;
		logic [WIDTH-1:0] exponent;
		logic [WIDTH-1:0] message;
		logic [WIDTH-1:0] modulus;
	} item_t;

	// (x + y) mod n for x, y below n.
	function automatic logic [WIDTH-1:0] add_mod(input logic [WIDTH-1:0] x,
		input logic [WIDTH-1:0] y, input logic [WIDTH-1:0] n);
		logic [WIDTH:0] s;
		s = {1'b0, x} + {1'b0, y};
		if (s >= {1'b0, n}) begin
			s = s - {1'b0, n};
		end
		return s[WIDTH-1:0];
	endfunction

endpackage

@@ hdl/modular_exponentiation.sv @@
// Channel        Direction  Handshake            Payload
// configuration  in         wr_en                wr_index, wr_data
// items          in         push / full          action, message
// results        out        pop / empty          result
//
// One shared bit-serial multiplier does a multiply per set exponent bit and a
// square per bit below the top set bit, with the leading zero bits skipped one
// per scan step; a zero exponent or zero modulus bypasses the multiplier.
// Reset sets the modulus and both exponents to 1 and empties the queues.
// A two-entry item queue and a result register let either side stall.
module modular_exponentiation (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              wr_en,
	input  logic [mexp_pkg::REG_IDX_W-1:0]    wr_index,
	input  logic [mexp_pkg::WIDTH-1:0]        wr_data,
	input  logic                              push,
	output logic                              full,
	input  logic                              action,
	input  logic [mexp_pkg::WIDTH-1:0]        message,
	output logic                              empty,
	input  logic                              pop,
	output logic [mexp_pkg::WIDTH-1:0]        result
);

	logic q_push;
	logic q_pop;
	logic q_full;
	logic q_empty;
	mexp_pkg::item_t in_item;
	mexp_pkg::item_t head_item;

	// The front end owns the configuration registers, picks the exponent that the
	// action selects, and sorts out the trivial cases before the item is queued.
	mexp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.push     (push),
		.action   (action),
		.message  (message),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_item   (in_item)
	);

	// Short queue that decouples accepting a transaction from working on it.
	mexp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (in_item),
		.pop       (q_pop),
		.head_item (head_item),
		.full      (q_full),
		.empty     (q_empty)
	);

	// The back end runs square and multiply over the exponent, most significant
	// bit first, and holds the finished result until it is popped.
	mexp_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_item  (head_item),
		.q_pop   (q_pop),
		.pop     (pop),
		.empty   (empty),
		.result  (result)
	);

	assign full = q_full;

	// The back end only takes an item that is really waiting.
	assert property (@(posedge clk) disable iff (!arst_n) q_pop |-> !q_empty)
		else $error("back end popped an empty item queue");

	// The front end never pushes into a full queue.
	assert property (@(posedge clk) disable iff (!arst_n) q_push |-> !q_full)
		else $error("front end pushed into a full item queue");

	// An accepted transaction lands in the item queue on the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(q_push && !q_pop) |=> !q_empty)
		else $error("pushed item did not reach the queue");

endmodule

@@ hdl/mexp_front.sv @@
module mexp_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  logic [mexp_pkg::REG_IDX_W-1:0]      wr_index,
	input  logic [mexp_pkg::WIDTH-1:0]          wr_data,
	input  logic                                push,
	input  logic                                action,
	input  logic [mexp_pkg::WIDTH-1:0]          message,
	input  logic                                q_full,
	output logic                                q_push,
	output mexp_pkg::item_t                     q_item
);

	logic [mexp_pkg::WIDTH-1:0] modulus_q;
	logic [mexp_pkg::WIDTH-1:0] public_exp_q;
	logic [mexp_pkg::WIDTH-1:0] private_exp_q;
	logic [mexp_pkg::WIDTH-1:0] exp_sel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= mexp_pkg::WIDTH'(1);
			public_exp_q <= mexp_pkg::WIDTH'(1);
			private_exp_q <= mexp_pkg::WIDTH'(1);
		end else if (wr_en) begin
			case (wr_index)
				mexp_pkg::REG_MODULUS: modulus_q <= wr_data;
				mexp_pkg::REG_PUBLIC_EXP: public_exp_q <= wr_data;
				mexp_pkg::REG_PRIVATE_EXP: private_exp_q <= wr_data;
				default: ;
			endcase
		end
	end

	assign exp_sel = action ? private_exp_q : public_exp_q;

	// A zero exponent gives one before anything else; a zero modulus gives zero.
	always_comb begin
		q_item.exponent = exp_sel;
		q_item.message = message;
		q_item.modulus = modulus_q;
		if (exp_sel == '0) begin
			q_item.cls = mexp_pkg::CLS_ONE;
		end else if (modulus_q == '0) begin
			q_item.cls = mexp_pkg::CLS_ZERO;
		end else begin
			q_item.cls = mexp_pkg::CLS_POW;
		end
	end

	assign q_push = push && !q_full;

endmodule

@@ hdl/mexp_queue.sv @@
module mexp_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  mexp_pkg::item_t push_item,
	input  logic            pop,
	output mexp_pkg::item_t head_item,
	output logic            full,
	output logic            empty
);

	mexp_pkg::item_t mem_q [mexp_pkg::QDEPTH];
	logic [mexp_pkg::QPTR_W-1:0] wptr_q;
	logic [mexp_pkg::QPTR_W-1:0] rptr_q;
	logic [mexp_pkg::QCNT_W-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign full = (count_q == mexp_pkg::QCNT_W'(mexp_pkg::QDEPTH));
	assign empty = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign head_item = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == mexp_pkg::QPTR_W'(mexp_pkg::QDEPTH - 1)) ? '0 :
					wptr_q + mexp_pkg::QPTR_W'(1);
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == mexp_pkg::QPTR_W'(mexp_pkg::QDEPTH - 1)) ? '0 :
					rptr_q + mexp_pkg::QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + mexp_pkg::QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - mexp_pkg::QCNT_W'(1);
			end
		end
	end

endmodule

@@ hdl/mexp_mul.sv @@
module mexp_mul (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [mexp_pkg::WIDTH-1:0] a,
	input  logic [mexp_pkg::WIDTH-1:0] b,
	input  logic [mexp_pkg::WIDTH-1:0] n,
	output logic                       done,
	output logic [mexp_pkg::WIDTH-1:0] p
);

	// Interleaved modular multiply: one bit of b per cycle, most significant first.
	// Requires a below n; b may be any value.
	logic [mexp_pkg::WIDTH-1:0] acc_q;
	logic [mexp_pkg::WIDTH-1:0] a_q;
	logic [mexp_pkg::WIDTH-1:0] b_q;
	logic [mexp_pkg::WIDTH-1:0] n_q;
	logic [mexp_pkg::IDX_W-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [mexp_pkg::WIDTH-1:0] dbl;
	logic [mexp_pkg::WIDTH-1:0] acc_next;

	assign dbl = mexp_pkg::add_mod(acc_q, acc_q, n_q);
	assign acc_next = b_q[mexp_pkg::WIDTH-1] ? mexp_pkg::add_mod(dbl, a_q, n_q) : dbl;

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			a_q <= a;
			b_q <= b;
			n_q <= n;
		end else if (busy_q) begin
			acc_q <= acc_next;
			b_q <= {b_q[mexp_pkg::WIDTH-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= mexp_pkg::IDX_W'(mexp_pkg::WIDTH - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - mexp_pkg::IDX_W'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign p = acc_q;

endmodule

@@ hdl/mexp_back.sv @@
module mexp_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       q_empty,
	input  mexp_pkg::item_t            q_item,
	output logic                       q_pop,
	input  logic                       pop,
	output logic                       empty,
	output logic [mexp_pkg::WIDTH-1:0] result
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_BIT = 2'd1;
	localparam logic [1:0] ST_MUL = 2'd2;
	localparam logic [1:0] ST_OUT = 2'd3;

	logic [1:0] state_q;
	logic [mexp_pkg::WIDTH-1:0] exp_q;
	logic [mexp_pkg::WIDTH-1:0] msg_q;
	logic [mexp_pkg::WIDTH-1:0] mod_q;
	logic [mexp_pkg::WIDTH-1:0] r_q;
	logic [mexp_pkg::IDX_W-1:0] idx_q;
	logic seen_q;
	logic square_q;
	logic start_q;
	logic [mexp_pkg::WIDTH-1:0] op_a_q;
	logic [mexp_pkg::WIDTH-1:0] op_b_q;
	logic [mexp_pkg::WIDTH-1:0] out_q;
	logic out_valid_q;
	logic mul_done;
	logic [mexp_pkg::WIDTH-1:0] mul_p;
	logic out_load;

	mexp_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_q),
		.a      (op_a_q),
		.b      (op_b_q),
		.n      (mod_q),
		.done   (mul_done),
		.p      (mul_p)
	);

	assign q_pop = (state_q == ST_IDLE) && !q_empty;
	assign out_load = (state_q == ST_OUT) && (!out_valid_q || pop);

	always_ff @(posedge clk) begin
		if (q_pop) begin
			exp_q <= q_item.exponent;
			msg_q <= q_item.message;
			mod_q <= q_item.modulus;
			idx_q <= mexp_pkg::IDX_W'(mexp_pkg::WIDTH - 1);
			case (q_item.cls)
				mexp_pkg::CLS_ONE: r_q <= mexp_pkg::WIDTH'(1);
				mexp_pkg::CLS_ZERO: r_q <= '0;
				default: r_q <= (q_item.modulus == mexp_pkg::WIDTH'(1)) ? '0 :
					mexp_pkg::WIDTH'(1);
			endcase
		end else if (state_q == ST_BIT) begin
			if (!exp_q[mexp_pkg::WIDTH-1] && !seen_q) begin
				exp_q <= {exp_q[mexp_pkg::WIDTH-2:0], 1'b0};
				idx_q <= idx_q - mexp_pkg::IDX_W'(1);
			end
			op_a_q <= r_q;
			op_b_q <= exp_q[mexp_pkg::WIDTH-1] ? msg_q : r_q;
		end else if (state_q == ST_MUL && mul_done) begin
			r_q <= mul_p;
			op_a_q <= mul_p;
			op_b_q <= mul_p;
			if (!(!square_q && idx_q != '0) && idx_q != '0) begin
				exp_q <= {exp_q[mexp_pkg::WIDTH-2:0], 1'b0};
				idx_q <= idx_q - mexp_pkg::IDX_W'(1);
			end
		end
		if (out_load) begin
			out_q <= r_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			seen_q <= 1'b0;
			square_q <= 1'b0;
			start_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			start_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						seen_q <= 1'b0;
						state_q <= (q_item.cls == mexp_pkg::CLS_POW) ? ST_BIT : ST_OUT;
					end
				end
				ST_BIT: begin
					if (exp_q[mexp_pkg::WIDTH-1]) begin
						seen_q <= 1'b1;
						square_q <= 1'b0;
						start_q <= 1'b1;
						state_q <= ST_MUL;
					end else if (seen_q) begin
						if (idx_q != '0) begin
							square_q <= 1'b1;
							start_q <= 1'b1;
							state_q <= ST_MUL;
						end else begin
							state_q <= ST_OUT;
						end
					end
				end
				ST_MUL: begin
					if (mul_done) begin
						if (!square_q && idx_q != '0) begin
							square_q <= 1'b1;
							start_q <= 1'b1;
						end else if (idx_q == '0) begin
							state_q <= ST_OUT;
						end else begin
							state_q <= ST_BIT;
						end
					end
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign empty = !out_valid_q;
	assign result = out_q;

endmodule
